// File: design/sea_pkg.sv
`default_nettype none
package sea_pkg;

	localparam int MemWords  = 65536;
	localparam int MaxFree   = 16;
	localparam int MaxBlocks = 16;
	localparam int MaxPieces = 32;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [16:0] alloc_size;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] logical_start;
		logic [15:0] piece_start;
		logic [15:0] piece_end;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_SCAN,
		S_A_EMIT,
		S_A_SHIFT,
		S_A_FIN,
		S_F_FIND,
		S_F_COPY,
		S_F_PSCAN,
		S_F_IFIND,
		S_F_IMERGE,
		S_F_SHL,
		S_F_SHR,
		S_F_BACK,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

// File: design/sea_ifs.sv
`default_nettype none
interface sea_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [16:0] alloc_size;
	logic [31:0] free_address;
	modport source (output valid, cmd, alloc_size, free_address, input ready);
	modport sink (input valid, cmd, alloc_size, free_address, output ready);
endinterface

interface sea_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] logical_start;
	logic [15:0] piece_start;
	logic [15:0] piece_end;
	logic        last;
	modport source (output valid, status, logical_start, piece_start, piece_end, last,
		input ready);
	modport sink (input valid, status, logical_start, piece_start, piece_end, last,
		output ready);
endinterface
`default_nettype wire

// File: design/sea_engine.sv
`default_nettype none
module sea_engine
	import sea_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_data,
	input  wire logic        req_valid,
	input  wire req_t        req,
	output logic             req_ready,
	output logic             res_valid,
	output res_t             res,
	input  wire logic        res_ready
);

	state_t state_q, state_d;

	logic [15:0] free_lo_q [MaxFree];
	logic [15:0] free_hi_q [MaxFree];
	logic [4:0]  free_count_q;
	logic [15:0] tlo_q [MaxFree];
	logic [15:0] thi_q [MaxFree];
	logic [4:0]  tcnt_q;
	logic [31:0] block_logical_q [MaxBlocks];
	logic [16:0] block_words_q [MaxBlocks];
	logic [MaxBlocks-1:0] block_valid_q;
	logic [15:0] piece_lo_q [MaxPieces];
	logic [15:0] piece_hi_q [MaxPieces];
	logic [3:0]  piece_owner_q [MaxPieces];
	logic [MaxPieces-1:0] piece_valid_q;
	logic [31:0] next_logical_q;
	logic [16:0] words_free_q;

	logic [16:0] size_q, rem_q;
	logic [31:0] la_q;
	logic [1:0]  st_q;
	logic [4:0]  idx_q, need_q, cons_q, k_q, p_q;
	logic [5:0]  j_q;
	logic [3:0]  blk_q;
	logic        blk_ok_q;
	logic [15:0] s_q, e_q;

	logic [15:0] cur_lo, cur_hi, pe;
	logic [16:0] cur_len, rem_next;
	logic        split, a_scan_go, shift_go, blk_hit, pc_hit, ifind_go, mp, mn;
	logic        shl_go, shr_go, last_piece;
	logic [4:0]  pslot;
	logic [3:0]  bfree;
	logic        bfree_ok;
	logic [5:0]  spare;
	logic [16:0] tot;
	logic [4:0]  pm1;
	logic [5:0]  kc;

	always_comb begin
		pslot = '0;
		for (int i = MaxPieces - 1; i >= 0; i--) begin
			if (!piece_valid_q[i]) pslot = 5'(i);
		end
		bfree = '0;
		bfree_ok = 1'b0;
		for (int i = MaxBlocks - 1; i >= 0; i--) begin
			if (!block_valid_q[i]) begin
				bfree = 4'(i);
				bfree_ok = 1'b1;
			end
		end
	end

	assign spare = 6'($countones(~piece_valid_q));
	assign tot = (cfg_data == 17'd0) ? 17'd1 :
		(cfg_data > 17'(MemWords)) ? 17'(MemWords) : cfg_data;

	assign cur_lo = free_lo_q[idx_q[3:0]];
	assign cur_hi = free_hi_q[idx_q[3:0]];
	assign cur_len = {1'b0, cur_hi} - {1'b0, cur_lo} + 17'd1;
	assign split = cur_len > rem_q;
	assign pe = split ? 16'(cur_lo + rem_q[15:0] - 16'd1) : cur_hi;
	assign rem_next = split ? 17'd0 : rem_q - cur_len;
	assign last_piece = rem_next == 17'd0;
	assign a_scan_go = idx_q < free_count_q && rem_q != 17'd0;
	assign kc = {1'b0, k_q} + {1'b0, cons_q};
	assign shift_go = kc < {1'b0, free_count_q};
	assign blk_hit = block_valid_q[blk_q] && block_logical_q[blk_q] == la_q;
	assign pc_hit = piece_valid_q[j_q[4:0]] && piece_owner_q[j_q[4:0]] == blk_q;
	assign ifind_go = p_q < tcnt_q && s_q > tlo_q[p_q[3:0]];
	assign pm1 = p_q - 5'd1;
	assign mp = p_q != 5'd0 && ({1'b0, thi_q[pm1[3:0]]} + 17'd1) == {1'b0, s_q};
	assign mn = p_q < tcnt_q && ({1'b0, e_q} + 17'd1) == {1'b0, tlo_q[p_q[3:0]]};
	assign shl_go = ({1'b0, k_q} + 6'd1) < {1'b0, tcnt_q};
	assign shr_go = k_q > p_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = (req.cmd == CMD_FREE) ? S_F_FIND :
					(req.alloc_size == 17'd0 || req.alloc_size > words_free_q) ? S_RESP :
					S_A_SCAN;
			end
			S_A_SCAN: begin
				if (!a_scan_go) state_d = (!blk_ok_q || rem_q != 17'd0 ||
					{1'b0, need_q} > spare) ? S_RESP : S_A_EMIT;
			end
			S_A_EMIT: begin
				if (res_ready && last_piece) state_d = S_A_SHIFT;
			end
			S_A_SHIFT: begin
				if (!shift_go) state_d = S_A_FIN;
			end
			S_A_FIN: state_d = S_IDLE;
			S_F_FIND: begin
				if (blk_hit) state_d = S_F_COPY;
				else if (blk_q == 4'(MaxBlocks - 1)) state_d = S_RESP;
			end
			S_F_COPY: begin
				if (k_q == 5'(MaxFree - 1)) state_d = S_F_PSCAN;
			end
			S_F_PSCAN: begin
				if (j_q == 6'(MaxPieces)) state_d = S_F_BACK;
				else if (pc_hit) state_d = S_F_IFIND;
			end
			S_F_IFIND: begin
				if (!ifind_go) state_d = S_F_IMERGE;
			end
			S_F_IMERGE: begin
				if (mp && mn) state_d = S_F_SHL;
				else if (mp || mn) state_d = S_F_PSCAN;
				else if (tcnt_q >= 5'(MaxFree)) state_d = S_RESP;
				else state_d = S_F_SHR;
			end
			S_F_SHL: begin
				if (!shl_go) state_d = S_F_PSCAN;
			end
			S_F_SHR: begin
				if (!shr_go) state_d = S_F_PSCAN;
			end
			S_F_BACK: begin
				if (k_q == 5'(MaxFree - 1)) state_d = S_RESP;
			end
			S_RESP: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		res = '0;
		case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_A_EMIT: begin
				res_valid = 1'b1;
				res.status = ST_OK;
				res.logical_start = la_q;
				res.piece_start = cur_lo;
				res.piece_end = pe;
				res.last = last_piece;
			end
			S_RESP: begin
				res_valid = 1'b1;
				res.status = st_q;
				res.logical_start = la_q;
				res.last = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < MaxFree; i++) begin
				free_lo_q[i] <= '0;
				free_hi_q[i] <= '0;
			end
			free_hi_q[0] <= 16'(MemWords - 1);
			free_count_q <= 5'd1;
			block_valid_q <= '0;
			piece_valid_q <= '0;
			next_logical_q <= '0;
			words_free_q <= 17'(MemWords);
		end else if (cfg_we) begin
			state_q <= S_IDLE;
			free_lo_q[0] <= '0;
			free_hi_q[0] <= 16'(tot - 17'd1);
			free_count_q <= 5'd1;
			block_valid_q <= '0;
			piece_valid_q <= '0;
			next_logical_q <= '0;
			words_free_q <= tot;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						size_q <= req.alloc_size;
						rem_q <= req.alloc_size;
						idx_q <= '0;
						need_q <= '0;
						blk_q <= (req.cmd == CMD_FREE) ? 4'd0 : bfree;
						blk_ok_q <= bfree_ok;
						la_q <= (req.cmd == CMD_FREE) ? req.free_address : next_logical_q;
						st_q <= ST_NOMEM;
					end
				end
				S_A_SCAN: begin
					if (a_scan_go) begin
						rem_q <= (cur_len >= rem_q) ? 17'd0 : rem_q - cur_len;
						need_q <= need_q + 5'd1;
						idx_q <= idx_q + 5'd1;
					end else begin
						st_q <= ST_FULL;
						rem_q <= size_q;
						idx_q <= '0;
						cons_q <= '0;
						k_q <= '0;
					end
				end
				S_A_EMIT: begin
					if (res_ready) begin
						piece_lo_q[pslot] <= cur_lo;
						piece_hi_q[pslot] <= pe;
						piece_owner_q[pslot] <= blk_q;
						piece_valid_q[pslot] <= 1'b1;
						if (split) free_lo_q[idx_q[3:0]] <= 16'(cur_lo + rem_q[15:0]);
						else cons_q <= cons_q + 5'd1;
						rem_q <= rem_next;
						idx_q <= idx_q + 5'd1;
					end
				end
				S_A_SHIFT: begin
					if (shift_go) begin
						free_lo_q[k_q[3:0]] <= free_lo_q[kc[3:0]];
						free_hi_q[k_q[3:0]] <= free_hi_q[kc[3:0]];
						k_q <= k_q + 5'd1;
					end else begin
						free_count_q <= free_count_q - cons_q;
					end
				end
				S_A_FIN: begin
					block_logical_q[blk_q] <= la_q;
					block_words_q[blk_q] <= size_q;
					block_valid_q[blk_q] <= 1'b1;
					words_free_q <= words_free_q - size_q;
					next_logical_q <= la_q + {15'd0, size_q};
				end
				S_F_FIND: begin
					k_q <= '0;
					if (!blk_hit) begin
						if (blk_q == 4'(MaxBlocks - 1)) st_q <= ST_UNKNOWN;
						else blk_q <= blk_q + 4'd1;
					end
				end
				S_F_COPY: begin
					tlo_q[k_q[3:0]] <= free_lo_q[k_q[3:0]];
					thi_q[k_q[3:0]] <= free_hi_q[k_q[3:0]];
					k_q <= k_q + 5'd1;
					tcnt_q <= free_count_q;
					j_q <= '0;
				end
				S_F_PSCAN: begin
					k_q <= '0;
					if (j_q != 6'(MaxPieces)) begin
						if (pc_hit) begin
							s_q <= piece_lo_q[j_q[4:0]];
							e_q <= piece_hi_q[j_q[4:0]];
							p_q <= '0;
						end
						j_q <= j_q + 6'd1;
					end
				end
				S_F_IFIND: begin
					if (ifind_go) p_q <= p_q + 5'd1;
				end
				S_F_IMERGE: begin
					if (mp && mn) begin
						thi_q[pm1[3:0]] <= thi_q[p_q[3:0]];
						k_q <= p_q;
					end else if (mp) begin
						thi_q[pm1[3:0]] <= e_q;
					end else if (mn) begin
						tlo_q[p_q[3:0]] <= s_q;
					end else begin
						st_q <= ST_FULL;
						k_q <= tcnt_q;
					end
				end
				S_F_SHL: begin
					if (shl_go) begin
						tlo_q[k_q[3:0]] <= tlo_q[k_q[3:0] + 4'd1];
						thi_q[k_q[3:0]] <= thi_q[k_q[3:0] + 4'd1];
						k_q <= k_q + 5'd1;
					end else begin
						tcnt_q <= tcnt_q - 5'd1;
					end
				end
				S_F_SHR: begin
					if (shr_go) begin
						tlo_q[k_q[3:0]] <= tlo_q[k_q[3:0] - 4'd1];
						thi_q[k_q[3:0]] <= thi_q[k_q[3:0] - 4'd1];
						k_q <= k_q - 5'd1;
					end else begin
						tlo_q[p_q[3:0]] <= s_q;
						thi_q[p_q[3:0]] <= e_q;
						tcnt_q <= tcnt_q + 5'd1;
					end
				end
				S_F_BACK: begin
					free_lo_q[k_q[3:0]] <= tlo_q[k_q[3:0]];
					free_hi_q[k_q[3:0]] <= thi_q[k_q[3:0]];
					k_q <= k_q + 5'd1;
					if (k_q == 5'(MaxFree - 1)) begin
						free_count_q <= tcnt_q;
						for (int i = 0; i < MaxPieces; i++) begin
							if (piece_owner_q[i] == blk_q) piece_valid_q[i] <= 1'b0;
						end
						block_valid_q[blk_q] <= 1'b0;
						words_free_q <= words_free_q + block_words_q[blk_q];
						st_q <= ST_OK;
					end
				end
				default: begin
					st_q <= st_q;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= 5'(MaxFree))
		else $error("free extent count out of range");
	a_trial_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_F_PSCAN |-> tcnt_q <= 5'(MaxFree))
		else $error("trial extent count out of range");
	a_emit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_EMIT |-> rem_q != 17'd0 && idx_q < free_count_q)
		else $error("piece emitted past the request size");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !cfg_we |=> !req_ready)
		else $error("request taken while busy");

endmodule
`default_nettype wire

// File: design/scatter_extent_allocator.sv
`default_nettype none
// First-fit allocator of up to 16 blocks over a scattered physical memory, with
// coalescing on free. One request is in work at a time; all table work goes
// through one scan/shift sequencer. Allocate scans the free extents, emits one
// piece per extent used and shifts the kept extents down; free looks up the
// block, copies the extent table, walks the piece table, inserting or merging
// each piece of the block, and writes the table back. Results leave through an
// output register, so the next request may enter while the final result waits.
// A write of cfg_data resets all tables.
module scatter_extent_allocator
	import sea_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_data,
	sea_req_if.sink          req,
	sea_res_if.source        res
);

	req_t req_w;
	res_t eres;
	logic eres_valid, eres_ready;
	logic out_valid_q;
	res_t out_q;

	assign req_w.cmd = req.cmd;
	assign req_w.alloc_size = req.alloc_size;
	assign req_w.free_address = req.free_address;

	sea_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req.valid),
		.req       (req_w),
		.req_ready (req.ready),
		.res_valid (eres_valid),
		.res       (eres),
		.res_ready (eres_ready)
	);

	assign eres_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eres_ready) begin
			out_valid_q <= eres_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eres_ready && eres_valid) out_q <= eres;
	end

	assign res.valid = out_valid_q;
	assign res.status = out_q.status;
	assign res.logical_start = out_q.logical_start;
	assign res.piece_start = out_q.piece_start;
	assign res.piece_end = out_q.piece_end;
	assign res.last = out_q.last;

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
	import sea_pkg::*;

	localparam int StallLimit = 6000;

	class alloc_scoreboard;
		int unsigned ext_lo[MaxFree], ext_hi[MaxFree], ext_cnt;
		int unsigned tmp_lo[MaxFree], tmp_hi[MaxFree], tmp_cnt;
		int unsigned blk_addr[MaxBlocks], blk_words[MaxBlocks];
		bit          blk_live[MaxBlocks];
		int unsigned pc_lo[MaxPieces], pc_hi[MaxPieces], pc_owner[MaxPieces];
		bit          pc_live[MaxPieces];
		int unsigned next_addr, words_left;
		res_t        pending[$];
		int          errors;

		function void configure(int unsigned total);
			if (total < 1) total = 1;
			if (total > MemWords) total = MemWords;
			foreach (blk_live[i]) blk_live[i] = 0;
			foreach (pc_live[i]) pc_live[i] = 0;
			ext_lo[0] = 0;
			ext_hi[0] = total - 1;
			ext_cnt = 1;
			next_addr = 0;
			words_left = total;
		endfunction

		function void push(logic [1:0] st, logic [31:0] la, int unsigned ps,
			int unsigned pe, logic lst);
			res_t r;
			r.status = st;
			r.logical_start = la;
			r.piece_start = ps[15:0];
			r.piece_end = pe[15:0];
			r.last = lst;
			pending.push_back(r);
		endfunction

		function bit merge_extent(int unsigned s, int unsigned e);
			int unsigned p;
			bit mp, mn;
			p = 0;
			while (p < tmp_cnt && s > tmp_lo[p]) p++;
			mp = p > 0 && tmp_hi[p-1] + 1 == s;
			mn = p < tmp_cnt && e + 1 == tmp_lo[p];
			if (mp && mn) begin
				tmp_hi[p-1] = tmp_hi[p];
				for (int unsigned k = p; k + 1 < tmp_cnt; k++) begin
					tmp_lo[k] = tmp_lo[k+1];
					tmp_hi[k] = tmp_hi[k+1];
				end
				tmp_cnt--;
			end else if (mp) begin
				tmp_hi[p-1] = e;
			end else if (mn) begin
				tmp_lo[p] = s;
			end else begin
				if (tmp_cnt >= MaxFree) return 0;
				for (int unsigned k = tmp_cnt; k > p; k--) begin
					tmp_lo[k] = tmp_lo[k-1];
					tmp_hi[k] = tmp_hi[k-1];
				end
				tmp_lo[p] = s;
				tmp_hi[p] = e;
				tmp_cnt++;
			end
			return 1;
		endfunction

		function void predict_alloc(int unsigned size);
			int unsigned la, rem, need, spare, b, used, slot, lo, hi, len, pe;
			la = next_addr;
			if (size == 0 || size > words_left) begin
				push(ST_NOMEM, la, 0, 0, 1);
				return;
			end
			b = 0;
			while (b < MaxBlocks && blk_live[b]) b++;
			rem = size;
			need = 0;
			for (int unsigned i = 0; i < ext_cnt && rem > 0; i++) begin
				len = ext_hi[i] - ext_lo[i] + 1;
				need++;
				rem = len >= rem ? 0 : rem - len;
			end
			spare = 0;
			foreach (pc_live[i]) if (!pc_live[i]) spare++;
			if (b >= MaxBlocks || rem > 0 || need > 16 || need > spare) begin
				push(ST_FULL, la, 0, 0, 1);
				return;
			end
			rem = size;
			used = 0;
			slot = 0;
			for (int unsigned i = 0; i < ext_cnt && rem > 0; i++) begin
				lo = ext_lo[i];
				hi = ext_hi[i];
				len = hi - lo + 1;
				if (len > rem) begin
					pe = lo + rem - 1;
					ext_lo[i] = lo + rem;
					rem = 0;
				end else begin
					pe = hi;
					used++;
					rem -= len;
				end
				while (pc_live[slot]) slot++;
				pc_lo[slot] = lo;
				pc_hi[slot] = pe;
				pc_owner[slot] = b;
				pc_live[slot] = 1;
				push(ST_OK, la, lo, pe, rem == 0);
			end
			for (int unsigned k = 0; k + used < ext_cnt; k++) begin
				ext_lo[k] = ext_lo[k+used];
				ext_hi[k] = ext_hi[k+used];
			end
			ext_cnt -= used;
			blk_addr[b] = la;
			blk_words[b] = size;
			blk_live[b] = 1;
			words_left -= size;
			next_addr = la + size;
		endfunction

		function void predict_free(int unsigned addr);
			int unsigned b;
			b = 0;
			while (b < MaxBlocks && !(blk_live[b] && blk_addr[b] == addr)) b++;
			if (b >= MaxBlocks) begin
				push(ST_UNKNOWN, addr, 0, 0, 1);
				return;
			end
			tmp_lo = ext_lo;
			tmp_hi = ext_hi;
			tmp_cnt = ext_cnt;
			foreach (pc_live[j])
				if (pc_live[j] && pc_owner[j] == b)
					if (!merge_extent(pc_lo[j], pc_hi[j])) begin
						push(ST_FULL, addr, 0, 0, 1);
						return;
					end
			foreach (pc_live[j]) if (pc_live[j] && pc_owner[j] == b) pc_live[j] = 0;
			ext_lo = tmp_lo;
			ext_hi = tmp_hi;
			ext_cnt = tmp_cnt;
			blk_live[b] = 0;
			words_left = (words_left + blk_words[b]) & 32'h1FFFF;
			push(ST_OK, addr, 0, 0, 1);
		endfunction

		function void note_request(req_t r);
			if (r.cmd == CMD_ALLOC) predict_alloc(r.alloc_size);
			else predict_free(r.free_address);
		endfunction

		function void check_result(res_t a);
			res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status)
				$display("%0t: status exp %0d got %0d", $time, e.status, a.status);
			if (a.logical_start !== e.logical_start)
				$display("%0t: logical_start exp %h got %h", $time, e.logical_start,
					a.logical_start);
			if (a.piece_start !== e.piece_start)
				$display("%0t: piece_start exp %h got %h", $time, e.piece_start,
					a.piece_start);
			if (a.piece_end !== e.piece_end)
				$display("%0t: piece_end exp %h got %h", $time, e.piece_end, a.piece_end);
			if (a.last !== e.last)
				$display("%0t: last exp %b got %b", $time, e.last, a.last);
			if (a !== e) errors++;
		endfunction

		function int unsigned pick_live(output bit found);
			int unsigned idx[$];
			foreach (blk_live[i]) if (blk_live[i]) idx.push_back(i);
			found = idx.size() != 0;
			if (!found) return 0;
			return blk_addr[idx[$urandom_range(0, idx.size() - 1)]];
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_data;
	sea_req_if   req_ch();
	sea_res_if   res_ch();

	alloc_scoreboard sb;
	int  idle_cycles;
	int  send_gap_max;
	int  recv_gap_max;
	bit  hold_output;

	scatter_extent_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req(req_ch.sink),
		.res(res_ch.source)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			req_t r;
			r.cmd = req_ch.cmd;
			r.alloc_size = req_ch.alloc_size;
			r.free_address = req_ch.free_address;
			sb.note_request(r);
		end
		if (res_ch.valid && res_ch.ready) begin
			res_t a;
			a.status = res_ch.status;
			a.logical_start = res_ch.logical_start;
			a.piece_start = res_ch.piece_start;
			a.piece_end = res_ch.piece_end;
			a.last = res_ch.last;
			sb.check_result(a);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		res_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				res_ch.ready = 0;
				repeat (400) @(negedge clk);
				hold_output = 0;
			end else begin
				int g;
				g = $urandom_range(0, recv_gap_max);
				res_ch.ready = 0;
				repeat (g) @(negedge clk);
				res_ch.ready = 1;
				do @(posedge clk); while (!res_ch.valid);
			end
		end
	end

	task automatic send(logic c, logic [16:0] size, logic [31:0] addr);
		int g;
		g = $urandom_range(0, send_gap_max);
		if (g > 0) begin
			req_ch.valid = 0;
			repeat (g) @(negedge clk);
		end
		req_ch.cmd = c;
		req_ch.alloc_size = size;
		req_ch.free_address = addr;
		req_ch.valid = 1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic alloc(logic [16:0] size);
		send(CMD_ALLOC, size, $urandom);
	endtask

	task automatic release_block(logic [31:0] addr);
		send(CMD_FREE, 17'($urandom), addr);
	endtask

	task automatic drain;
		req_ch.valid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_total(logic [16:0] v);
		cfg_we = 1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		sb.configure(v);
		@(negedge clk);
	endtask

	task automatic random_items(int n, int unsigned size_cap);
		int unsigned a;
		bit ok;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				send_gap_max = (i % 80 == 0) ? 0 : 8;
				recv_gap_max = (i % 120 == 40) ? 0 : 8;
			end
			case ($urandom_range(0, 19))
				0: alloc(17'($urandom));
				1: alloc($urandom_range(0, 1) ? 17'd0 : 17'h10000);
				2: release_block($urandom);
				3, 4: alloc(17'($urandom_range(1, 4096)));
				5, 6, 7, 8, 9, 10: begin
					a = sb.pick_live(ok);
					if (ok) release_block(a);
					else alloc(17'($urandom_range(1, size_cap)));
				end
				default: alloc(17'($urandom_range(1, size_cap)));
			endcase
		end
	endtask

	initial begin
		sb = new();
		sb.configure(MemWords);
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		req_ch.valid = 0;
		req_ch.cmd = CMD_ALLOC;
		req_ch.alloc_size = 0;
		req_ch.free_address = 0;
		idle_cycles = 0;
		send_gap_max = 8;
		recv_gap_max = 8;
		hold_output = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		alloc(0);
		alloc(17'h10000);
		alloc(1);
		release_block(0);
		release_block(0);
		release_block(32'hFFFFFFFF);
		for (int i = 0; i < 17; i++) alloc(100);
		release_block(100);
		release_block(300);
		alloc(150);
		drain();

		random_items(40, 64);
		drain();

		write_total(200);
		hold_output = 1;
		random_items(35, 24);
		drain();

		write_total(0);
		alloc(1);
		alloc(1);
		release_block(0);
		alloc(17'h1FFFF);
		drain();

		write_total(17'h1FFFF);
		random_items(30, 512);
		drain();

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
